/* rtl/core/vef_pkg.sv */
package vef_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef logic [7:0]  chan_t;
    typedef logic [31:0] rgba_t;
    typedef logic [23:0] rgb_t;

    typedef struct packed {
        logic             emit;
        logic             done;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
    } pos_t;

    function automatic chan_t sat_diff(input chan_t above, input chan_t below);
        sat_diff = (above > below) ? chan_t'(above - below) : chan_t'(0);
    endfunction

endpackage

/* rtl/core/vef_if.sv */
interface vef_pix_if;
    logic          valid;
    logic          ready;
    vef_pkg::chan_t red;
    vef_pkg::chan_t green;
    vef_pkg::chan_t blue;
    vef_pkg::chan_t alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface vef_res_if;
    logic                          valid;
    logic                          ready;
    vef_pkg::chan_t                out_red;
    vef_pkg::chan_t                out_green;
    vef_pkg::chan_t                out_blue;
    vef_pkg::chan_t                out_alpha;
    logic [vef_pkg::ROW_W-1:0]     out_row;
    logic [vef_pkg::COL_W-1:0]     out_column;
    logic                          frame_done;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, out_row,
                    out_column, frame_done, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, out_row,
                    out_column, frame_done, output ready);
endinterface

interface vef_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [vef_pkg::CFG_IDX_W-1:0]     index;
    logic [vef_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/vef_ctrl.sv */
module vef_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    vef_cfg_if.sink       cfg,
    input  logic          accept,
    output vef_pkg::pos_t pos
);
    import vef_pkg::*;

    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WIDTH_REG_W-1:0]  w_val;
    logic [HEIGHT_REG_W-1:0] h_val;
    logic             cfg_wr;
    logic             restart;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;
    assign w_val     = cfg.data[WIDTH_REG_W-1:0];
    assign h_val     = cfg.data[HEIGHT_REG_W-1:0];
    assign restart   = cfg_wr && (cfg.index == REG_IMAGE_WIDTH ||
                                  cfg.index == REG_IMAGE_HEIGHT);

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_wr && cfg.index == REG_IMAGE_WIDTH)
        begin
            if (w_val < WIDTH_REG_W'(3))
                last_col_next = COL_W'(2);
            else if (w_val > WIDTH_REG_W'(MAX_WIDTH))
                last_col_next = COL_W'(MAX_WIDTH - 1);
            else
                last_col_next = COL_W'(w_val - WIDTH_REG_W'(1));
        end
        if (cfg_wr && cfg.index == REG_IMAGE_HEIGHT)
        begin
            if (h_val < HEIGHT_REG_W'(3))
                last_row_next = ROW_W'(2);
            else if (h_val > HEIGHT_REG_W'(MAX_HEIGHT))
                last_row_next = ROW_W'(MAX_HEIGHT - 1);
            else
                last_row_next = ROW_W'(h_val - HEIGHT_REG_W'(1));
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + ROW_W'(1);
            end
            else
                col_next = col_reg + COL_W'(1);
        end
        else
        begin
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= COL_W'(MAX_WIDTH - 1);
            last_row_reg <= ROW_W'(MAX_HEIGHT - 1);
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    // result for the centre one row up
    assign pos.emit   = (row_reg >= ROW_W'(2)) && (col_reg != '0) && (col_reg < last_col_reg);
    assign pos.done   = (row_reg == last_row_reg) && (col_reg == last_col_reg - COL_W'(1));
    assign pos.row    = row_reg - ROW_W'(1);
    assign pos.column = col_reg;

endmodule

/* rtl/core/vef_line_buf.sv */
module vef_line_buf (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [vef_pkg::COL_W-1:0] addr,
    input  vef_pkg::rgba_t            pixel,
    output vef_pkg::rgb_t             above,
    output vef_pkg::rgba_t            centre
);
    import vef_pkg::*;

    rgb_t  older_mem  [MAX_WIDTH];
    rgba_t middle_mem [MAX_WIDTH];

    rgb_t             above_reg;
    rgba_t            centre_reg;
    logic             wr_pend_reg;
    logic [COL_W-1:0] wr_addr_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            above_reg        <= older_mem[addr];
            centre_reg       <= middle_mem[addr];
            middle_mem[addr] <= pixel;
            wr_addr_reg      <= addr;
        end
    end

    // old middle row moves into the older row in the cycle after the accept
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
            older_mem[wr_addr_reg] <= centre_reg[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_pend_reg <= 1'b0;
        else
            wr_pend_reg <= accept;
    end

    assign above  = above_reg;
    assign centre = centre_reg;

endmodule

/* rtl/core/vef_out_stage.sv */
module vef_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  vef_pkg::rgb_t  above,
    input  vef_pkg::rgba_t centre,
    input  vef_pkg::rgb_t  below,
    input  vef_pkg::pos_t  pos,
    output logic           space,
    vef_res_if.source      res
);
    import vef_pkg::*;

    logic             valid_reg, valid_next;
    chan_t            red_reg, green_reg, blue_reg, alpha_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             done_reg;

    assign space = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (load)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= sat_diff(above[7:0],   below[7:0]);
            green_reg <= sat_diff(above[15:8],  below[15:8]);
            blue_reg  <= sat_diff(above[23:16], below[23:16]);
            alpha_reg <= centre[31:24];
            row_reg   <= pos.row;
            col_reg   <= pos.column;
            done_reg  <= pos.done;
        end
    end

    assign res.valid      = valid_reg;
    assign res.out_red    = red_reg;
    assign res.out_green  = green_reg;
    assign res.out_blue   = blue_reg;
    assign res.out_alpha  = alpha_reg;
    assign res.out_row    = row_reg;
    assign res.out_column = col_reg;
    assign res.frame_done = done_reg;

endmodule

/* rtl/core/vertical_emboss_filter.sv */
// Timing: the line buffers and stage-1 registers load on the accept edge, and the result
// register loads from them when the output has space. The filter takes 1 pixel per cycle
// unless the output stalls; each pixel does one read and one write per line buffer.
// Border pixels give no result; a pixel is still taken every cycle while the output drains.
// Reset: counters cleared, width 1024, height 4096; line buffers are not cleared,
// every entry is written before its value is used within a frame.
module vertical_emboss_filter (
    input  logic      clk,
    input  logic      rst_n,
    vef_pix_if.sink   pix,
    vef_res_if.source res,
    vef_cfg_if.sink   cfg
);
    import vef_pkg::*;

    pos_t  pos;
    pos_t  s1_pos_reg;
    rgb_t  s1_below_reg;
    logic  s1_valid_reg, s1_valid_next;
    rgb_t  above;
    rgba_t centre;
    logic  accept;
    logic  space;
    logic  advance;

    assign advance   = s1_valid_reg && space;
    assign pix.ready = !s1_valid_reg || space;
    assign accept    = pix.valid && pix.ready;

    vef_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .pos    (pos)
    );

    vef_line_buf u_line_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .addr   (pos.column),
        .pixel  ({pix.alpha, pix.blue, pix.green, pix.red}),
        .above  (above),
        .centre (centre)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        priority if (accept)
            s1_valid_next = pos.emit;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg   <= pos;
            s1_below_reg <= {pix.blue, pix.green, pix.red};
        end
    end

    vef_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .above  (above),
        .centre (centre),
        .below  (s1_below_reg),
        .pos    (s1_pos_reg),
        .space  (space),
        .res    (res)
    );

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !space |=> s1_valid_reg && $stable(s1_pos_reg))
        else $error("stalled item lost or changed");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> pix.ready)
        else $error("input blocked with empty stage");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.out_row != '0 && res.out_column != '0)
        else $error("border result produced");

    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_pos_reg.emit)
        else $error("non-interior item held for output");

endmodule

/* dv/vertical_emboss_filter_test.sv */
module vertical_emboss_filter_test;
    import vef_pkg::*;

    localparam int          RANDOM_ITEMS = 790;
    localparam int          DRAIN_CYCLES = 4;
    localparam int unsigned MIN_DIM      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = REG_IMAGE_HEIGHT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = '1;

    typedef enum logic {STEP_REG, STEP_PIX} step_kind_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } pixel_t;

    typedef struct packed {
        chan_t            red;
        chan_t            green;
        chan_t            blue;
        chan_t            alpha;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             done;
    } emboss_t;

    typedef struct packed {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        pixel_t                px;
        logic                  typed;
        emboss_t               want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;

    vef_pix_if pix ();
    vef_res_if res ();
    vef_cfg_if cfg ();

    vertical_emboss_filter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res),
        .cfg   (cfg)
    );

    // own copy of the filter state
    rgb_t                    line_above  [MAX_WIDTH];
    rgba_t                   line_centre [MAX_WIDTH];
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [WIDTH_REG_W-1:0]  reg_width;
    logic [HEIGHT_REG_W-1:0] reg_height;

    emboss_t emboss_due [$];
    emboss_t due_now;
    step_t   script [0:20];
    bit      mismatch_seen = 1'b0;
    bit      calm = 1'b0;
    int      ready_left = 0;
    logic    ready_next = 1'b1;
    int      random_items = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned eff_width();
        return clamp_dim(reg_width, MAX_WIDTH);
    endfunction

    function automatic int unsigned eff_height();
        return clamp_dim(reg_height, MAX_HEIGHT);
    endfunction

    function automatic chan_t clip_sub(input chan_t a, input chan_t b);
        return (a > b) ? chan_t'(a - b) : chan_t'(0);
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] index,
                                            input logic [CFG_DATA_W-1:0] data);
        if (index == REG_IMAGE_WIDTH)
            reg_width = data[WIDTH_REG_W-1:0];
        else if (index == REG_IMAGE_HEIGHT)
            reg_height = data[HEIGHT_REG_W-1:0];
        else
            return;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic bit predict_emboss(input pixel_t p, output emboss_t e);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        rgb_t        above;
        rgba_t       centre;
        bit          hit;
        w      = eff_width();
        h      = eff_height();
        c      = col_pos;
        r      = row_pos;
        above  = line_above[c];
        centre = line_centre[c];
        hit    = (r >= 2) && (c >= 1) && (c + 2 <= w);
        e.red    = clip_sub(above[7:0], p.red);
        e.green  = clip_sub(above[15:8], p.green);
        e.blue   = clip_sub(above[23:16], p.blue);
        e.alpha  = centre[31:24];
        e.row    = ROW_W'(r - 1);
        e.column = COL_W'(c);
        e.done   = (r + 1 == h) && (c + 2 == w);
        line_above[c]  = centre[23:0];
        line_centre[c] = {p.alpha, p.blue, p.green, p.red};
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
        return hit;
    endfunction

    function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] index,
                                      input logic [CFG_DATA_W-1:0] data);
        return '{STEP_REG, index, data, '0, 1'b0, '0};
    endfunction

    function automatic step_t pix_row(input chan_t r, input chan_t g, input chan_t b,
                                      input chan_t a);
        return '{STEP_PIX, '0, '0, '{r, g, b, a}, 1'b0, '0};
    endfunction

    function automatic step_t pix_want(input chan_t r, input chan_t g, input chan_t b,
                                       input chan_t a, input emboss_t want);
        return '{STEP_PIX, '0, '0, '{r, g, b, a}, 1'b1, want};
    endfunction

    function automatic chan_t pick_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return chan_t'($urandom_range(120, 136));
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p.red   = pick_chan();
        p.green = pick_chan();
        p.blue  = pick_chan();
        p.alpha = pick_chan();
        return p;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    // block quiet and no results pending
    task automatic settle();
        @(negedge clk);
        pix.valid <= 1'b0;
        while (emboss_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        apply_reg_write(index, data);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic push_pixel(input pixel_t p, input logic typed, input emboss_t want);
        emboss_t e;
        bit      hit;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        pix.valid <= 1'b1;
        pix.red   <= p.red;
        pix.green <= p.green;
        pix.blue  <= p.blue;
        pix.alpha <= p.alpha;
        do
            @(posedge clk);
        while (!pix.ready);
        hit = predict_emboss(p, e);
        if (typed)
            emboss_due.push_back(want);
        else if (hit)
            emboss_due.push_back(e);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd,
                             input int n);
        write_reg(REG_IMAGE_WIDTH, wd);
        write_reg(REG_IMAGE_HEIGHT, hd);
        repeat (n) push_pixel(random_pixel(), 1'b0, '0);
    endtask

    // result side stalls in bursts
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            if (calm || $urandom_range(0, 3) != 0)
            begin
                ready_next = 1'b1;
                ready_left = $urandom_range(1, 30);
            end
            else
            begin
                ready_next = 1'b0;
                ready_left = $urandom_range(1, 10);
            end
        end
        ready_left--;
        res.ready <= ready_next;
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (emboss_due.size() == 0)
            begin
                $display("%0t: result expected none got row %0d column %0d", $time,
                         res.out_row, res.out_column);
                mismatch_seen = 1'b1;
            end
            else
            begin
                due_now = emboss_due.pop_front();
                check_field("out_red", due_now.red, res.out_red);
                check_field("out_green", due_now.green, res.out_green);
                check_field("out_blue", due_now.blue, res.out_blue);
                check_field("out_alpha", due_now.alpha, res.out_alpha);
                check_field("out_row", due_now.row, res.out_row);
                check_field("out_column", due_now.column, res.out_column);
                check_field("frame_done", due_now.done, res.frame_done);
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("vertical_emboss_filter_test: FAIL");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        int                    frame;
        int                    n;
        int                    split;
        pix.valid  = 1'b0;
        pix.red    = '0;
        pix.green  = '0;
        pix.blue   = '0;
        pix.alpha  = '0;
        cfg.valid  = 1'b0;
        cfg.index  = '0;
        cfg.data   = '0;
        rst_n      = 1'b0;
        reg_width  = WIDTH_REG_W'(MAX_WIDTH);
        reg_height = HEIGHT_REG_W'(MAX_HEIGHT);
        col_pos    = 0;
        row_pos    = 0;

        // two 3x3 frames: full positive swing, then full negative swing
        script = '{
            reg_row(REG_IMAGE_WIDTH, 13'd0),
            reg_row(REG_IMAGE_HEIGHT, 13'd1),
            pix_row(8'd10, 8'd20, 8'd30, 8'd40),
            pix_row(8'd255, 8'd255, 8'd255, 8'd1),
            pix_row(8'd7, 8'd8, 8'd9, 8'd2),
            pix_row(8'd1, 8'd2, 8'd3, 8'd4),
            pix_row(8'd50, 8'd60, 8'd70, 8'hA5),
            pix_row(8'd5, 8'd6, 8'd7, 8'd8),
            pix_row(8'd11, 8'd12, 8'd13, 8'd14),
            pix_want(8'd0, 8'd0, 8'd0, 8'd0,
                     '{8'd255, 8'd255, 8'd255, 8'hA5, 12'd1, 10'd1, 1'b1}),
            pix_row(8'd99, 8'd98, 8'd97, 8'd96),
            reg_row(REG_TOP_INDEX, 13'h1FFF),
            pix_row(8'd200, 8'd100, 8'd50, 8'd0),
            pix_row(8'd0, 8'd0, 8'd0, 8'd255),
            pix_row(8'd1, 8'd1, 8'd1, 8'd1),
            pix_row(8'd2, 8'd2, 8'd2, 8'd2),
            pix_row(8'd128, 8'd128, 8'd128, 8'h5A),
            pix_row(8'd3, 8'd3, 8'd3, 8'd3),
            pix_row(8'd4, 8'd4, 8'd4, 8'd4),
            pix_want(8'd255, 8'd255, 8'd255, 8'd255,
                     '{8'd0, 8'd0, 8'd0, 8'h5A, 12'd1, 10'd1, 1'b1}),
            pix_row(8'd6, 8'd6, 8'd6, 8'd6)
        };

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == STEP_REG)
                write_reg(script[i].index, script[i].data);
            else
                push_pixel(script[i].px, script[i].typed, script[i].want);
        end

        // size extremes; width 2047 clamps to full width
        run_phase(13'h07FF, 13'd3, 40);
        run_phase(13'd1024, 13'd3, 40);
        run_phase(13'd3, 13'd4096, 30);
        run_phase(13'd1, 13'h1FFF, 20);
        run_phase(13'h1803, 13'd4, 12);

        while (random_items < RANDOM_ITEMS)
        begin
            calm = (random_items >= RANDOM_ITEMS - 100) || ($urandom_range(0, 4) == 0);
            wd = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                              : CFG_DATA_W'($urandom_range(3, 12));
            if ($urandom_range(0, 3) == 0)
                wd[CFG_DATA_W-1:WIDTH_REG_W] = 2'($urandom_range(1, 3));
            hd = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                              : CFG_DATA_W'($urandom_range(3, 7));
            if (!($urandom_range(0, 3) == 0 && eff_width() <= 12))
                write_reg(REG_IMAGE_WIDTH, wd);
            if (!($urandom_range(0, 3) == 0 && eff_height() <= 7))
                write_reg(REG_IMAGE_HEIGHT, hd);
            frame = eff_width() * eff_height();
            case ($urandom_range(0, 5))
                0:       n = $urandom_range(1, frame - 1);
                1:       n = 2 * frame;
                default: n = frame;
            endcase
            split = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int k = 0; k < n; k++)
            begin
                if (k == split)
                    write_reg(CFG_IDX_W'($urandom_range(REG_PAST_LAST, REG_TOP_INDEX)),
                              CFG_DATA_W'($urandom));
                push_pixel(random_pixel(), 1'b0, '0);
                random_items++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (!mismatch_seen)
            $display("vertical_emboss_filter_test: PASS");
        else
            $display("vertical_emboss_filter_test: FAIL");
        $finish;
    end

endmodule
